/* src/ordered_presence_list_tracker_top_assert.svh */
// Assertion macros shared by the checker of the presence list tracker.
// Used by oplt_checker.sv; expects a clock named clk and a reset named rst.
`ifndef ORDERED_PRESENCE_LIST_TRACKER_TOP_ASSERT_SVH
`define ORDERED_PRESENCE_LIST_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define OPLT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oplt: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define OPLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("oplt: next-cycle check failed");

`endif

/* src/oplt_pkg.sv */
// Shared types and constants of the ordered presence list tracker.
// No dependencies; imported by the top level and by its checker.
`timescale 1ns / 1ps

package oplt_pkg;

  // Field widths of the stream payloads.
  localparam int IDX_W   = 10;
  localparam int POS_W   = 4;
  localparam int COUNT_W = 5;

  // At most this many entries are sent out by one close tick.
  localparam int EMIT_MAX = 16;

  // Bit positions of the result fields inside the output tdata.
  localparam int OUT_IDX_LSB  = 0;
  localparam int OUT_POS_LSB  = OUT_IDX_LSB + IDX_W;
  localparam int OUT_PRES_LSB = OUT_POS_LSB + POS_W;
  localparam int OUT_PEND_LSB = OUT_PRES_LSB + COUNT_W;
  localparam int OUT_DROP_LSB = OUT_PEND_LSB + COUNT_W;
  localparam int OUT_DATA_W   = 32;
  localparam int IN_DATA_W    = 16;

  // Input item kinds, carried on the input tuser.
  typedef enum logic [1:0] {
    ACT_ARRIVE = 2'd0,
    ACT_MERGE  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_t;

endpackage

/* src/ordered_presence_list_tracker_top.sv */
// Ordered presence list tracker: top level with the sequencer and both list memories.
// Depends on oplt_pkg.
`timescale 1ns / 1ps

//  Channel   | Direction | Payload
//  ----------+-----------+---------------------------------------------------------
//  s_axis    | in        | tuser: action; tdata: object_id
//  m_axis    | out       | tuser: entry_valid; tlast: last; tdata: index, position,
//            |           |   present count, pending count, dropped
//  cfg       | in        | cfg_wen / cfg_wdata write id_offset, no read-back
//
// One item is worked on at a time; s_axis_tready is high only while the sequencer idles.
// An arrival walks the pending list once; an arrival below the offset goes straight to a status
// result. A close tick compares every present entry against the pending list, walks the pending
// list once more for the rest, then emits one result per present entry, up to EMIT_MAX, or one
// status result; clear and unused codes go straight to a status result.
// All walks use the single compare path against the registered memory read ports.
// Reset is synchronous and clears sizes, marks and control; no clearing pass is needed.
// The output register holds a finished result until it is taken, while the next item
// may already be accepted; a stalled output only delays the loading of the next result.

module ordered_presence_list_tracker_top #(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: id_offset in bits 9:0
  input  logic        cfg_wen,
  input  logic [9:0]  cfg_wdata,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [9:0] object_id, [15:10] zero
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [9:0] agent_index, [13:10] position,
                                      // [18:14] present_count, [23:19] pending_count,
                                      // [24] dropped, [31:25] zero
  output logic [0:0]  m_axis_tuser,   // [0] entry_valid
  output logic        m_axis_tlast
);

  import oplt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = CW + COUNT_W;

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_ARR    = 8'b0000_0010,
    ST_MPRES  = 8'b0000_0100,
    ST_MSCAN  = 8'b0000_1000,
    ST_MREST  = 8'b0001_0000,
    ST_EFETCH = 8'b0010_0000,
    ST_ELOAD  = 8'b0100_0000,
    ST_STATUS = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  logic [IDX_W-1:0] id_offset;
  logic [IDX_W-1:0] arr_idx;
  logic             drop;
  logic [CW-1:0]    pres_size, pend_size;
  logic [CW-1:0]    i_cnt, j_cnt, n_cnt, k_cnt;
  logic [AW-1:0]    jp;
  logic             cmp_v;
  logic [CAPACITY-1:0] taken;

  // List memories with registered read data.
  logic [IDX_W-1:0] present_mem [CAPACITY];
  logic [IDX_W-1:0] pending_mem [CAPACITY];
  logic [IDX_W-1:0] pres_rd, pend_rd;
  logic [AW-1:0]    pres_raddr, pend_raddr;
  logic             pres_we, pend_we;
  logic [IDX_W-1:0] pres_wdata;

  // Output register.
  logic             out_valid;
  logic             out_entry;
  logic [IDX_W-1:0] out_index;
  logic [POS_W-1:0] out_pos;
  logic             out_last;
  logic [COUNT_W-1:0] out_pres, out_pend;
  logic             out_drop;

  logic in_fire, out_free, out_load;
  logic scan_more, scan_end;
  logic arr_hit, m_hit, r_take;
  logic emit_last;
  logic [WW-1:0] pres_wide, pend_wide, k_wide;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign out_load      = out_free && ((state == ST_ELOAD) || (state == ST_STATUS));

  // Walk of the pending list: j_cnt is the address being read, jp the address whose data
  // sits in pend_rd when cmp_v is set.
  assign scan_more = (j_cnt < pend_size);
  assign scan_end  = !scan_more && !cmp_v;

  assign pend_raddr = (j_cnt < CW'(CAPACITY)) ? j_cnt[AW-1:0] : '0;

  always_comb begin
    if (state == ST_EFETCH || state == ST_ELOAD) begin
      pres_raddr = (k_cnt < CW'(CAPACITY)) ? k_cnt[AW-1:0] : '0;
    end else begin
      pres_raddr = (i_cnt < CW'(CAPACITY)) ? i_cnt[AW-1:0] : '0;
    end
  end

  // Compare outcomes of the shared unit for each walking state.
  assign arr_hit = cmp_v && (pend_rd == arr_idx);
  assign m_hit   = cmp_v && !taken[jp] && (pend_rd == pres_rd);
  assign r_take  = cmp_v && !taken[jp] && (n_cnt < CW'(CAPACITY));

  assign pend_we = (state == ST_ARR) && !arr_hit && scan_end && (pend_size < CW'(CAPACITY));
  assign pres_we = ((state == ST_MSCAN) && m_hit) || ((state == ST_MREST) && r_take);
  assign pres_wdata = (state == ST_MSCAN) ? pres_rd : pend_rd;

  // Counts widened so that a five-bit slice works for any capacity.
  assign pres_wide = {{COUNT_W{1'b0}}, pres_size};
  assign pend_wide = {{COUNT_W{1'b0}}, pend_size};
  assign k_wide    = {{COUNT_W{1'b0}}, k_cnt};
  assign emit_last = ((k_wide + WW'(1)) == pres_wide) || (k_wide == WW'(EMIT_MAX - 1));

  always_ff @(posedge clk) begin
    if (pend_we) begin
      pending_mem[pend_size[AW-1:0]] <= arr_idx;
    end
    pend_rd <= pending_mem[pend_raddr];
  end

  always_ff @(posedge clk) begin
    if (pres_we) begin
      present_mem[n_cnt[AW-1:0]] <= pres_wdata;
    end
    pres_rd <= present_mem[pres_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      id_offset <= '0;
    end else if (cfg_wen) begin
      id_offset <= cfg_wdata;
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          case (s_axis_tuser)
            ACT_ARRIVE: begin
              state_next = (s_axis_tdata[IDX_W-1:0] < id_offset) ? ST_STATUS : ST_ARR;
            end
            ACT_MERGE: state_next = ST_MPRES;
            default:   state_next = ST_STATUS;
          endcase
        end
      end
      ST_ARR: begin
        if (arr_hit || scan_end) begin
          state_next = ST_STATUS;
        end
      end
      ST_MPRES:  state_next = (i_cnt < pres_size) ? ST_MSCAN : ST_MREST;
      ST_MSCAN: begin
        if (m_hit || scan_end) begin
          state_next = ST_MPRES;
        end
      end
      ST_MREST: begin
        if (scan_end) begin
          state_next = (n_cnt == '0) ? ST_STATUS : ST_EFETCH;
        end
      end
      ST_EFETCH: state_next = ST_ELOAD;
      ST_ELOAD: begin
        if (out_free) begin
          state_next = emit_last ? ST_IDLE : ST_EFETCH;
        end
      end
      ST_STATUS: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pres_size <= '0;
      pend_size <= '0;
      taken     <= '0;
      cmp_v     <= 1'b0;
      drop      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      // A result taken in the same cycle as a new one is loaded keeps the register full.
      if (out_valid && m_axis_tready && !out_load) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            j_cnt <= '0;
            cmp_v <= 1'b0;
            case (s_axis_tuser)
              ACT_ARRIVE: begin
                drop    <= (s_axis_tdata[IDX_W-1:0] < id_offset);
                arr_idx <= s_axis_tdata[IDX_W-1:0] - id_offset;
              end
              ACT_MERGE: begin
                drop  <= 1'b0;
                taken <= '0;
                i_cnt <= '0;
                n_cnt <= '0;
              end
              ACT_CLEAR: begin
                drop      <= 1'b0;
                pres_size <= '0;
                pend_size <= '0;
              end
              default: begin
                drop <= 1'b0;
              end
            endcase
          end
        end
        ST_ARR: begin
          if (!arr_hit && scan_end) begin
            if (pend_size < CW'(CAPACITY)) begin
              pend_size <= pend_size + CW'(1);
            end else begin
              drop <= 1'b1;
            end
          end else if (!arr_hit) begin
            cmp_v <= scan_more;
            jp    <= pend_raddr;
            if (scan_more) begin
              j_cnt <= j_cnt + CW'(1);
            end
          end
        end
        ST_MPRES: begin
          j_cnt <= '0;
          cmp_v <= 1'b0;
        end
        ST_MSCAN: begin
          if (m_hit) begin
            taken[jp] <= 1'b1;
            n_cnt     <= n_cnt + CW'(1);
            i_cnt     <= i_cnt + CW'(1);
          end else if (scan_end) begin
            i_cnt <= i_cnt + CW'(1);
          end else begin
            cmp_v <= scan_more;
            jp    <= pend_raddr;
            if (scan_more) begin
              j_cnt <= j_cnt + CW'(1);
            end
          end
        end
        ST_MREST: begin
          if (scan_end) begin
            pres_size <= n_cnt;
            pend_size <= '0;
            k_cnt     <= '0;
          end else begin
            if (r_take) begin
              taken[jp] <= 1'b1;
              n_cnt     <= n_cnt + CW'(1);
            end
            cmp_v <= scan_more;
            jp    <= pend_raddr;
            if (scan_more) begin
              j_cnt <= j_cnt + CW'(1);
            end
          end
        end
        ST_EFETCH: begin
          cmp_v <= 1'b0;
        end
        ST_ELOAD: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_entry <= 1'b1;
            out_index <= pres_rd;
            out_pos   <= k_wide[POS_W-1:0];
            out_last  <= emit_last;
            out_pres  <= pres_wide[COUNT_W-1:0];
            out_pend  <= pend_wide[COUNT_W-1:0];
            out_drop  <= 1'b0;
            k_cnt     <= k_cnt + CW'(1);
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_entry <= 1'b0;
            out_index <= '0;
            out_pos   <= '0;
            out_last  <= 1'b1;
            out_pres  <= pres_wide[COUNT_W-1:0];
            out_pend  <= pend_wide[COUNT_W-1:0];
            out_drop  <= drop;
          end
        end
        default: begin
          cmp_v <= 1'b0;
        end
      endcase
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tuser[0] = out_entry;
  assign m_axis_tlast    = out_last;
  assign m_axis_tdata    = {{(OUT_DATA_W - OUT_DROP_LSB - 1){1'b0}}, out_drop, out_pend,
                            out_pres, out_pos, out_index};

endmodule

/* src/oplt_checker.sv */
// Port-level checker of the ordered presence list tracker, bound to its top level.
// Depends on oplt_pkg and ordered_presence_list_tracker_top_assert.svh.
`timescale 1ns / 1ps
`include "ordered_presence_list_tracker_top_assert.svh"

module oplt_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wen,
  input logic [9:0]  cfg_wdata,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [15:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  import oplt_pkg::*;

  logic status_out;
  assign status_out = m_axis_tvalid && !m_axis_tuser[0];

  // A status result is always the only, and therefore last, result of its item.
  `OPLT_ASSERT_NOW(a_status_last, status_out, m_axis_tlast)

  // A status result carries neither an index nor a position.
  `OPLT_ASSERT_NOW(a_status_blank, status_out, m_axis_tdata[OUT_PRES_LSB-1:0] == '0)

  // Only a status result can report a dropped arrival.
  `OPLT_ASSERT_NOW(a_drop_status, m_axis_tvalid && m_axis_tdata[OUT_DROP_LSB], !m_axis_tuser[0])

  // The block works on one item at a time: it is busy right after taking one.
  `OPLT_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule

bind ordered_presence_list_tracker_top oplt_checker u_oplt_checker (.*);
